// ===== sv/xfd_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the xor file decrypter
package xfd_pkg;

	localparam int MAX_KEY_BYTES = 8;
	localparam int HDR_LEN       = 16;
	localparam int SIG_LEN       = 8;
	localparam int CNT_W         = 5;
	localparam int IDX_W         = 4;
	localparam int KPOS_W        = 3;
	localparam int KLEN_W        = 4;
	localparam int SUM_W         = 64;
	localparam int CFG_IDX_W     = 2;
	localparam int Q_DEPTH       = 2;
	localparam int Q_AW          = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd1;

	localparam logic [1:0] VS_NONE     = 2'd0;
	localparam logic [1:0] VS_MATCH    = 2'd1;
	localparam logic [1:0] VS_MISMATCH = 2'd2;

	// signature bytes, byte 0 in bits 7..0
	localparam logic [8*SIG_LEN-1:0] SIG_WORD = 64'h0052_4554_5059_5243;

	typedef enum logic [1:0] {
		PH_COLLECT,
		PH_KEYED,
		PH_PLAIN,
		PH_FLUSH
	} phase_t;

	typedef enum logic [1:0] {
		OP_DATA,
		OP_HDR,
		OP_HDR_END
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       data;
		logic             last_run;
		logic             file_end;
		logic [SUM_W-1:0] csum;
	} qent_t;

endpackage

// ===== sv/xfd_queue.sv =====
`timescale 1ns / 1ps
// small request queue between the front and back parts
module xfd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  xfd_pkg::qent_t push_ent,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output xfd_pkg::qent_t head
);
	import xfd_pkg::*;

	qent_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_AW:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == Q_DEPTH[Q_AW:0]);
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

endmodule

// ===== sv/xfd_front.sv =====
`timescale 1ns / 1ps
// front part: header collection, header check and flush sequencing
module xfd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          file_end,
	input  logic          q_full,
	output logic          q_push,
	output xfd_pkg::qent_t q_ent
);
	import xfd_pkg::*;

	phase_t              state_q;
	phase_t              state_d;
	logic [7:0]          buf_q [HDR_LEN];
	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    fidx_q;
	logic                flush_last_q;
	logic                take;
	logic                hdr_byte;
	logic                sig_ok;
	logic [SUM_W-1:0]    csum;
	logic                hdr_ok;
	logic                flush_lr;

	always_comb begin
		sig_ok = 1'b1;
		for (int i = 0; i < SIG_LEN; i++) begin
			if (buf_q[i] != SIG_WORD[8*i +: 8]) begin
				sig_ok = 1'b0;
			end
		end
	end

	assign csum = {buf_q[8], buf_q[9], buf_q[10], buf_q[11],
		buf_q[12], buf_q[13], buf_q[14], data_byte};
	assign hdr_ok   = sig_ok && (csum != '0);
	assign hdr_byte = (cnt_q == CNT_W'(HDR_LEN - 1));
	assign flush_lr = ({1'b0, fidx_q} == (cnt_q - 1'b1));
	assign in_ready = (state_q != PH_FLUSH) && !q_full;
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d        = state_q;
		q_push         = 1'b0;
		q_ent.op       = OP_DATA;
		q_ent.data     = data_byte;
		q_ent.last_run = 1'b1;
		q_ent.file_end = file_end;
		q_ent.csum     = csum;
		unique case (state_q)
			PH_COLLECT: begin
				if (take) begin
					if (hdr_byte) begin
						if (hdr_ok) begin
							q_push   = 1'b1;
							q_ent.op = file_end ? OP_HDR_END : OP_HDR;
							state_d  = file_end ? PH_COLLECT : PH_KEYED;
						end else begin
							state_d = PH_FLUSH;
						end
					end else if (file_end) begin
						state_d = PH_FLUSH;
					end
				end
			end
			PH_FLUSH: begin
				q_ent.data     = buf_q[fidx_q];
				q_ent.last_run = flush_lr;
				q_ent.file_end = flush_last_q && flush_lr;
				if (!q_full) begin
					q_push = 1'b1;
					if (flush_lr) begin
						state_d = flush_last_q ? PH_COLLECT : PH_PLAIN;
					end
				end
			end
			PH_KEYED, PH_PLAIN: begin
				if (take) begin
					q_push = 1'b1;
					if (file_end) begin
						state_d = PH_COLLECT;
					end
				end
			end
			default: begin
				state_d = PH_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= PH_COLLECT;
			cnt_q        <= '0;
			fidx_q       <= '0;
			flush_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				PH_COLLECT: begin
					if (take) begin
						cnt_q        <= (state_d == PH_COLLECT && file_end) ? '0 : cnt_q + 1'b1;
						flush_last_q <= file_end;
						fidx_q       <= '0;
					end
				end
				PH_FLUSH: begin
					if (q_push) begin
						fidx_q <= fidx_q + 1'b1;
						if (flush_lr) begin
							cnt_q <= '0;
						end
					end
				end
				default: begin
					cnt_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == PH_COLLECT && take) begin
			buf_q[cnt_q[IDX_W-1:0]] <= data_byte;
		end
	end

endmodule

// ===== sv/xfd_back.sv =====
`timescale 1ns / 1ps
// back part: key registers, decryption, running sum and verdict
module xfd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [xfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data,
	input  logic                            q_valid,
	input  xfd_pkg::qent_t                  q_head,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      plain_byte,
	output logic                            byte_valid,
	output logic                            last_of_run,
	output logic                            file_done,
	output logic [1:0]                      verify_status
);
	import xfd_pkg::*;

	logic [8*MAX_KEY_BYTES-1:0] key_q;
	logic [KLEN_W-1:0]          klen_q;
	logic [KPOS_W-1:0]          kpos_q;
	logic [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]           cs_q;
	logic                       keyed_q;
	logic                       out_valid_q;
	logic [7:0]                 plain_q;
	logic                       bv_q;
	logic                       lr_q;
	logic                       fd_q;
	logic [1:0]                 vs_q;
	logic [KLEN_W-1:0]          eff_len;
	logic [KPOS_W-1:0]          pos;
	logic [KLEN_W-1:0]          pos_inc;
	logic [KPOS_W-1:0]          pos_next;
	logic [7:0]                 kbyte;
	logic [7:0]                 ptext;
	logic [SUM_W-1:0]           sum_n;

	always_comb begin
		if (klen_q == '0) begin
			eff_len = KLEN_W'(1);
		end else if (klen_q > KLEN_W'(MAX_KEY_BYTES)) begin
			eff_len = KLEN_W'(MAX_KEY_BYTES);
		end else begin
			eff_len = klen_q;
		end
	end

	assign pos      = ({1'b0, kpos_q} >= eff_len) ? '0 : kpos_q;
	assign pos_inc  = {1'b0, pos} + 1'b1;
	assign pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[KPOS_W-1:0];
	assign kbyte    = key_q[{pos, 3'b000} +: 8];
	assign ptext    = q_head.data ^ kbyte;
	assign sum_n    = sum_q + {{(SUM_W-8){1'b0}}, ptext};

	assign q_pop = q_valid && (q_head.op == OP_HDR || !out_valid_q || out_ready);

	assign out_valid     = out_valid_q;
	assign plain_byte    = plain_q;
	assign byte_valid    = bv_q;
	assign last_of_run   = lr_q;
	assign file_done     = fd_q;
	assign verify_status = vs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			klen_q      <= KLEN_W'(1);
			kpos_q      <= '0;
			sum_q       <= '0;
			cs_q        <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_KEY_BYTES) begin
					key_q <= cfg_data;
				end else if (cfg_index == CFG_KEY_LENGTH) begin
					klen_q <= cfg_data[KLEN_W-1:0];
				end
			end
			if (q_pop && q_head.op != OP_HDR) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				unique case (q_head.op)
					OP_DATA: begin
						if (q_head.file_end) begin
							kpos_q  <= '0;
							sum_q   <= '0;
							cs_q    <= '0;
							keyed_q <= 1'b0;
						end else begin
							kpos_q <= pos_next;
							sum_q  <= sum_n;
						end
					end
					OP_HDR: begin
						cs_q    <= q_head.csum;
						keyed_q <= 1'b1;
					end
					OP_HDR_END: begin
						kpos_q  <= '0;
						sum_q   <= '0;
						cs_q    <= '0;
						keyed_q <= 1'b0;
					end
					default: begin
						keyed_q <= keyed_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			unique case (q_head.op)
				OP_DATA: begin
					plain_q <= ptext;
					bv_q    <= 1'b1;
					lr_q    <= q_head.last_run;
					fd_q    <= q_head.file_end;
					if (q_head.file_end && keyed_q) begin
						vs_q <= (~sum_n == cs_q) ? VS_MATCH : VS_MISMATCH;
					end else begin
						vs_q <= VS_NONE;
					end
				end
				OP_HDR_END: begin
					plain_q <= '0;
					bv_q    <= 1'b0;
					lr_q    <= 1'b1;
					fd_q    <= 1'b1;
					vs_q    <= (q_head.csum == '1) ? VS_MATCH : VS_MISMATCH;
				end
				default: begin
					plain_q <= plain_q;
				end
			endcase
		end
	end

endmodule

// ===== sv/xor_file_decrypt_with_header_check.sv =====
`timescale 1ns / 1ps
// top level of the xor file decrypter with header check
//
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    data_byte, file_end
// out      source     out_valid / out_ready  plain_byte, byte_valid, last_of_run,
//                                            file_done, verify_status
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one request per cycle in steady state, unless the output stalls and the queue fills;
// a rejected header or a short file holds the input while the flush replays the
// buffered bytes (up to 16). a result passes through the queue and the output
// register after its request is accepted.
// reset clears all control state; the header buffer needs no clearing.
// the front and back stall on their own across a two-entry queue.
module xor_file_decrypt_with_header_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	input  logic                            file_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      plain_byte,
	output logic                            byte_valid,
	output logic                            last_of_run,
	output logic                            file_done,
	output logic [1:0]                      verify_status,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [xfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data
);
	import xfd_pkg::*;

	logic  q_full;
	logic  q_push;
	logic  q_pop;
	logic  q_valid;
	qent_t q_ent;
	qent_t q_head;

	assign cfg_ready = 1'b1;

	xfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.file_end  (file_end),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_ent     (q_ent)
	);

	xfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (q_ent),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	xfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.plain_byte    (plain_byte),
		.byte_valid    (byte_valid),
		.last_of_run   (last_of_run),
		.file_done     (file_done),
		.verify_status (verify_status)
	);

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the xor file decrypter with header check
module tb;
	import xfd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int ITEM_GOAL   = 260;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_WAIT = 8;
	localparam int NO_SPLIT    = -1;

	class decrypt_scoreboard;
		typedef struct packed {
			logic [7:0] data;
			logic       has_data;
			logic       run_end;
			logic       done;
			logic [1:0] status;
		} plain_result_t;

		logic [63:0]   key_bytes;
		logic [3:0]    key_length;
		logic [7:0]    hdr [HDR_LEN];
		int            seen;
		phase_t        phase;
		int            key_pos;
		logic [63:0]   sum;
		logic [63:0]   stored_cs;
		plain_result_t due[$];
		int            errors;

		function new();
			key_bytes  = '0;
			key_length = 4'd1;
			errors     = 0;
			restart_file();
		endfunction

		function void restart_file();
			seen      = 0;
			phase     = PH_COLLECT;
			key_pos   = 0;
			sum       = '0;
			stored_cs = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
			if (idx == CFG_KEY_BYTES) begin
				key_bytes = v;
			end else if (idx == CFG_KEY_LENGTH) begin
				key_length = v[KLEN_W-1:0];
			end
		endfunction

		function int key_span();
			int n;
			n = key_length;
			if (n == 0) n = 1;
			if (n > MAX_KEY_BYTES) n = MAX_KEY_BYTES;
			return n;
		endfunction

		function logic [7:0] decrypt_next(logic [7:0] d);
			int n;
			logic [7:0] p;
			n = key_span();
			if (key_pos >= n) key_pos = 0;
			p = d ^ key_bytes[8*key_pos +: 8];
			key_pos = (key_pos + 1 >= n) ? 0 : key_pos + 1;
			sum += 64'(p);
			return p;
		endfunction

		function void note_request(logic [7:0] d, logic fe);
			plain_result_t run[$];
			plain_result_t r;
			bit accept;
			logic [63:0] cs;
			int cnt;
			accept = 1'b0;
			if (phase == PH_COLLECT) begin
				hdr[seen % HDR_LEN] = d;
				seen++;
				if (seen >= HDR_LEN) begin
					cs = '0;
					accept = 1'b1;
					for (int i = 0; i < SIG_LEN; i++)
						if (hdr[i] != SIG_WORD[8*i +: 8]) accept = 1'b0;
					for (int i = SIG_LEN; i < HDR_LEN; i++)
						cs = {cs[55:0], hdr[i]};
					if (cs == '0) accept = 1'b0;
					if (accept) begin
						stored_cs = cs;
						phase = PH_KEYED;
						if (!fe) return;
						run.push_back('0);
					end else begin
						phase = PH_PLAIN;
					end
				end else if (!fe) begin
					return;
				end
				if (!accept) begin
					cnt = (seen > HDR_LEN) ? HDR_LEN : seen;
					phase = PH_PLAIN;
					for (int i = 0; i < cnt; i++) begin
						r = '0;
						r.data = decrypt_next(hdr[i]);
						r.has_data = 1'b1;
						run.push_back(r);
					end
				end
			end else begin
				r = '0;
				r.data = decrypt_next(d);
				r.has_data = 1'b1;
				run.push_back(r);
			end
			r = run.pop_back();
			r.run_end = 1'b1;
			if (fe) begin
				r.done = 1'b1;
				if (phase != PH_KEYED) r.status = VS_NONE;
				else r.status = (~sum == stored_cs) ? VS_MATCH : VS_MISMATCH;
				restart_file();
			end else if (seen > HDR_LEN) begin
				seen = HDR_LEN;
			end
			run.push_back(r);
			foreach (run[i]) due.push_back(run[i]);
		endfunction

		function void check_result(logic [7:0] pb, logic bv, logic lr, logic fd, logic [1:0] vs);
			plain_result_t want;
			if (due.size() == 0) begin
				$error("unexpected result: plain_byte %0h", pb);
				errors++;
				return;
			end
			want = due.pop_front();
			if (pb !== want.data) begin
				$error("plain_byte: expected %0h, got %0h", want.data, pb);
				errors++;
			end
			if (bv !== want.has_data) begin
				$error("byte_valid: expected %0b, got %0b", want.has_data, bv);
				errors++;
			end
			if (lr !== want.run_end) begin
				$error("last_of_run: expected %0b, got %0b", want.run_end, lr);
				errors++;
			end
			if (fd !== want.done) begin
				$error("file_done: expected %0b, got %0b", want.done, fd);
				errors++;
			end
			if (vs !== want.status) begin
				$error("verify_status: expected %0d, got %0d", want.status, vs);
				errors++;
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [7:0]           data_byte = '0;
	logic                 file_end  = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [7:0]           plain_byte;
	logic                 byte_valid;
	logic                 last_of_run;
	logic                 file_done;
	logic [1:0]           verify_status;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data  = '0;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_toggle   = 1'b0;
	logic hold_seen     = 1'b0;
	int   hold_left     = 0;
	int   items_sent    = 0;

	decrypt_scoreboard sb;

	xor_file_decrypt_with_header_check DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb: errors");
		$finish;
	end

	// receiver: check accepted results, then pick next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(plain_byte, byte_valid, last_of_run, file_done, verify_status);
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic fe);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= d;
		file_end  <= fe;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(d, fe);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// split: index of the byte before which the key length is rewritten
	task automatic send_file(input logic [7:0] f[$], input int split);
		for (int i = 0; i < f.size(); i++) begin
			if (i == split) begin
				wait_idle();
				write_reg(CFG_KEY_LENGTH, {$urandom, $urandom});
			end
			send_byte(f[i], i == f.size() - 1);
		end
	endtask

	function automatic void build_keyed(output logic [7:0] f[$], input int n, input bit good);
		logic [63:0] total;
		logic [63:0] cs;
		logic [7:0]  p;
		logic [7:0]  body[$];
		int          pos;
		int          span;
		total = '0;
		pos   = 0;
		span  = sb.key_span();
		f     = {};
		repeat (n) begin
			p = 8'($urandom);
			total += 64'(p);
			body.push_back(p ^ sb.key_bytes[8*pos +: 8]);
			pos = (pos + 1) % span;
		end
		cs = good ? ~total : ({$urandom, $urandom} | 64'd1);
		for (int i = 0; i < SIG_LEN; i++) f.push_back(SIG_WORD[8*i +: 8]);
		for (int i = SIG_LEN - 1; i >= 0; i--) f.push_back(cs[8*i +: 8]);
		foreach (body[i]) f.push_back(body[i]);
	endfunction

	function automatic void build_noise(output logic [7:0] f[$], input int n);
		f = {};
		repeat (n) f.push_back(8'($urandom));
	endfunction

	initial begin
		logic [7:0]           f[$];
		logic [CFG_IDX_W-1:0] idx;
		int                   kind;
		int                   split;
		int                   start;
		int                   done_items;
		int                   pos;
		bit                   pressed;

		sb = new();
		pressed = 1'b0;
		send_idle_pct <= 30;
		recv_idle_pct <= 49;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unused register slots, then a one-byte file on reset config
		write_reg(CFG_SPARE_A, '1);
		write_reg(CFG_SPARE_B, 64'h5555_5555_5555_5555);
		f = {8'hFF};
		send_file(f, NO_SPLIT);
		wait_idle();

		// zero key length acts as one
		write_reg(CFG_KEY_BYTES, '1);
		write_reg(CFG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
		f = {8'h00, 8'h80};
		send_file(f, NO_SPLIT);
		wait_idle();

		// oversize key length, header only file, then a short file
		write_reg(CFG_KEY_BYTES, 64'h0123_4567_89AB_CDEF);
		write_reg(CFG_KEY_LENGTH, 64'hF);
		build_keyed(f, 0, 1'b1);
		send_file(f, NO_SPLIT);
		f = {8'h7F, 8'h01, 8'h00, 8'hFF};
		send_file(f, NO_SPLIT);

		start = items_sent;
		while (items_sent - start < ITEM_GOAL) begin
			done_items = items_sent - start;
			if (done_items < ITEM_GOAL / 3) begin
				send_idle_pct <= 30;
				recv_idle_pct <= 49;
			end else if (done_items < 2 * ITEM_GOAL / 3) begin
				send_idle_pct <= 49;
				recv_idle_pct <= 30;
			end else begin
				send_idle_pct <= 0;
				recv_idle_pct <= 0;
				if (!pressed) begin
					// long receiver stall while the sender keeps pushing
					pressed = 1'b1;
					wait_idle();
					hold_toggle <= ~hold_toggle;
					build_noise(f, 40);
					send_file(f, NO_SPLIT);
					continue;
				end
			end

			if ($urandom_range(0, 4) == 0) begin
				wait_idle();
				idx = CFG_IDX_W'($urandom);
				write_reg(idx, {$urandom, $urandom});
			end

			kind  = $urandom_range(0, 99);
			split = NO_SPLIT;
			if (kind < 60) begin
				build_keyed(f, $urandom_range(0, 20), $urandom_range(0, 3) != 0);
				if (f.size() > HDR_LEN + 1 && $urandom_range(0, 9) == 0)
					split = $urandom_range(HDR_LEN + 1, f.size() - 1);
			end else if (kind < 75) begin
				// broken header: bad signature byte or zero checksum
				build_keyed(f, $urandom_range(0, 12), 1'b1);
				if ($urandom_range(0, 1)) begin
					pos = $urandom_range(0, SIG_LEN - 1);
					f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
				end else begin
					for (int i = SIG_LEN; i < HDR_LEN; i++) f[i] = 8'h00;
				end
			end else if (kind < 90) begin
				build_noise(f, $urandom_range(1, HDR_LEN - 1));
			end else begin
				build_noise(f, $urandom_range(HDR_LEN, 40));
			end
			send_file(f, split);
		end

		wait_idle();
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/xfd_pkg.sv
sv/xfd_queue.sv
sv/xfd_front.sv
sv/xfd_back.sv
sv/xor_file_decrypt_with_header_check.sv
bench/tb.sv
